@@ design/tmpsc_pkg.sv @@
// Shared types, constants and speed-to-power line coefficients for the motor speed controller.
package tmpsc_pkg;

    localparam int MOTOR_COUNT = 3;
    localparam int LINE_COUNT  = 3;

    localparam int CFG_INDEX_W = 2;

    localparam logic [15:0] PROP_GAIN_RST     = 16'd3277;
    localparam logic [15:0] INTEG_GAIN_RST    = 16'd1229;
    localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd3277;
    localparam logic [7:0]  POWER_LIMIT_RST   = 8'd127;

    // Q16.16 intercepts and Q0.16 inverse slopes, one set per line
    localparam logic signed [39:0] X_CUT [LINE_COUNT] = '{
        40'sd234199, 40'sd162123, 40'sd206406
    };
    localparam logic signed [39:0] Y_CUT [LINE_COUNT] = '{
        -40'sd289590, -40'sd196706, -40'sd243453
    };
    localparam logic [15:0] INV_SLOPE [LINE_COUNT] = '{
        16'd53001, 16'd54015, 16'd55563
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PROP_GAIN     = 2'd0,
        CFG_INTEG_GAIN    = 2'd1,
        CFG_SAMPLE_PERIOD = 2'd2,
        CFG_POWER_LIMIT   = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        STEP_ERR_MUL = 3'd0,
        STEP_INTEG   = 3'd1,
        STEP_IGAIN   = 3'd2,
        STEP_SUM     = 3'd3,
        STEP_OFFSET  = 3'd4,
        STEP_SLOPE   = 3'd5
    } step_t;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] sample_period;
        logic [7:0]  power_limit;
    } cfg_t;

    typedef struct packed {
        logic  start;
        logic  run;
        step_t step;
    } lane_ctrl_t;

endpackage

@@ design/tmpsc_if.sv @@
// Channel interfaces: sample input, result output and configuration writes.
interface tmpsc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] enc_a;
    logic [15:0] enc_b;
    logic [15:0] enc_c;
    logic [7:0]  want_a;
    logic [7:0]  want_b;
    logic [7:0]  want_c;
    logic [7:0]  dir_in_a;
    logic [7:0]  dir_in_b;
    logic [7:0]  dir_in_c;
    logic [7:0]  act_in_a;
    logic [7:0]  act_in_b;
    logic [7:0]  act_in_c;

    modport source (
        output valid, enc_a, enc_b, enc_c, want_a, want_b, want_c,
               dir_in_a, dir_in_b, dir_in_c, act_in_a, act_in_b, act_in_c,
        input  ready
    );
    modport sink (
        input  valid, enc_a, enc_b, enc_c, want_a, want_b, want_c,
               dir_in_a, dir_in_b, dir_in_c, act_in_a, act_in_b, act_in_c,
        output ready
    );
endinterface

interface tmpsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] power_a;
    logic [7:0] power_b;
    logic [7:0] power_c;
    logic [7:0] dir_out_a;
    logic [7:0] dir_out_b;
    logic [7:0] dir_out_c;
    logic [7:0] act_out_a;
    logic [7:0] act_out_b;
    logic [7:0] act_out_c;

    modport source (
        output valid, power_a, power_b, power_c, dir_out_a, dir_out_b, dir_out_c,
               act_out_a, act_out_b, act_out_c,
        input  ready
    );
    modport sink (
        input  valid, power_a, power_b, power_c, dir_out_a, dir_out_b, dir_out_c,
               act_out_a, act_out_b, act_out_c,
        output ready
    );
endinterface

interface tmpsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/tmpsc_lane.sv @@
// One motor lane: error, saturating integral, PI sum and linear power map over six steps.
module tmpsc_lane #(
    parameter int LINE_IDX = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tmpsc_pkg::lane_ctrl_t  ctrl,
    input  tmpsc_pkg::cfg_t        cfg,
    input  logic [15:0]            enc,
    input  logic [7:0]             want,
    input  logic [7:0]             dir_in,
    input  logic [7:0]             act_in,
    output logic [7:0]             power,
    output logic [7:0]             dir_out,
    output logic [7:0]             act_out
);
    import tmpsc_pkg::*;

    localparam int LINE = LINE_IDX % LINE_COUNT;

    logic [16:0]        speed_reg;
    logic [16:0]        speed_next;
    logic signed [16:0] err_reg;
    logic signed [16:0] err_next;
    logic [7:0]         dir_reg;
    logic [7:0]         act_reg;
    logic signed [33:0] inc_reg;
    logic signed [33:0] inc_next;
    logic signed [33:0] pprod_reg;
    logic signed [33:0] pprod_next;
    logic signed [31:0] integral_reg;
    logic signed [31:0] integral_next;
    logic signed [34:0] integ_wide;
    logic signed [48:0] iprod_reg;
    logic signed [48:0] iprod_next;
    logic signed [39:0] sum_reg;
    logic signed [39:0] sum_next;
    logic signed [39:0] dist_wide;
    logic               below_reg;
    logic               below_next;
    logic [25:0]        dist_reg;
    logic [25:0]        dist_next;
    logic [41:0]        prod_reg;
    logic [41:0]        prod_next;
    logic [9:0]         level;

    always_comb
    begin
        speed_next = enc[15] ? 17'(-$signed({1'b1, enc})) : {1'b0, enc};
        err_next   = 17'({10'd0, want} - {1'b0, speed_next});

        inc_next   = err_reg * $signed({1'b0, cfg.sample_period});
        pprod_next = err_reg * $signed({1'b0, cfg.prop_gain});

        integ_wide = integral_reg + inc_reg;
        if (integ_wide > 35'sd2147483647)
        begin
            integral_next = 32'sh7FFF_FFFF;
        end
        else if (integ_wide < -35'sd2147483648)
        begin
            integral_next = 32'sh8000_0000;
        end
        else
        begin
            integral_next = integ_wide[31:0];
        end

        iprod_next = integral_reg * $signed({1'b0, cfg.integ_gain});

        sum_next = (40'(pprod_reg) <<< 4) + 40'(iprod_reg >>> 12)
                 + $signed({7'd0, speed_reg, 16'd0});

        // beyond 2^26 the power is far above any clamp, so saturate the distance
        dist_wide  = sum_reg - Y_CUT[LINE];
        below_next = sum_reg < X_CUT[LINE];
        dist_next  = (|dist_wide[39:26]) ? '1 : dist_wide[25:0];

        prod_next = dist_reg * INV_SLOPE[LINE];

        level = prod_reg[41:32];
        if (below_reg)
        begin
            power = 8'd0;
        end
        else if (level > {2'b00, cfg.power_limit})
        begin
            power = cfg.power_limit;
        end
        else
        begin
            power = level[7:0];
        end
    end

    assign dir_out = dir_reg;
    assign act_out = act_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
        end
        else if (ctrl.run && ctrl.step == STEP_INTEG)
        begin
            integral_reg <= integral_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            speed_reg <= speed_next;
            err_reg   <= err_next;
            dir_reg   <= dir_in;
            act_reg   <= act_in;
        end
        if (ctrl.run)
        begin
            case (ctrl.step)
                STEP_ERR_MUL:
                begin
                    inc_reg   <= inc_next;
                    pprod_reg <= pprod_next;
                end
                STEP_IGAIN:
                begin
                    iprod_reg <= iprod_next;
                end
                STEP_SUM:
                begin
                    sum_reg <= sum_next;
                end
                STEP_OFFSET:
                begin
                    below_reg <= below_next;
                    dist_reg  <= dist_next;
                end
                STEP_SLOPE:
                begin
                    prod_reg <= prod_next;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ design/tmpsc_merge.sv @@
// Output stage: gathers the lane results into one held result item.
module tmpsc_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [7:0]          power   [tmpsc_pkg::MOTOR_COUNT],
    input  logic [7:0]          dir_val [tmpsc_pkg::MOTOR_COUNT],
    input  logic [7:0]          act_val [tmpsc_pkg::MOTOR_COUNT],
    output logic                free,
    tmpsc_out_if.source         result
);
    import tmpsc_pkg::*;

    logic       valid_reg;
    logic [7:0] power_reg [MOTOR_COUNT];
    logic [7:0] dir_reg   [MOTOR_COUNT];
    logic [7:0] act_reg   [MOTOR_COUNT];

    assign free = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            power_reg <= power;
            dir_reg   <= dir_val;
            act_reg   <= act_val;
        end
    end

    assign result.valid     = valid_reg;
    assign result.power_a   = power_reg[0];
    assign result.power_b   = power_reg[1];
    assign result.power_c   = power_reg[2];
    assign result.dir_out_a = dir_reg[0];
    assign result.dir_out_b = dir_reg[1];
    assign result.dir_out_c = dir_reg[2];
    assign result.act_out_a = act_reg[0];
    assign result.act_out_b = act_reg[1];
    assign result.act_out_c = act_reg[2];

endmodule

@@ design/three_motor_pi_speed_control.sv @@
// Top level: configuration registers, step sequencer, three motor lanes and output stage.
//
//  channel  | dir | handshake     | content
//  ---------+-----+---------------+--------------------------------------------
//  sample   | in  | valid/ready   | enc, want, dir_in, act_in for motors a..c
//  result   | out | valid/ready   | power, dir_out, act_out for motors a..c
//  cfg      | in  | valid/ready   | index (0..3), data; ready is always high
//
//  An item passes through accept, six lane steps (the multiply chain of
//  error*period, integral, gain*integral, sum, offset and slope product),
//  then the move of the lane results into the output register.
//  The next item is accepted while the previous result still waits there;
//  a stalled output holds the finished lanes until the register frees.
//  Reset clears the integrals and loads the default gains, period and clamp.
module three_motor_pi_speed_control (
    input  logic         clk,
    input  logic         rst_n,
    tmpsc_in_if.sink     sample,
    tmpsc_out_if.source  result,
    tmpsc_cfg_if.sink    cfg
);
    import tmpsc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    step_t      step_reg;
    step_t      step_next;
    cfg_t       cfg_reg;
    lane_ctrl_t ctrl;
    logic       accept;
    logic       load;
    logic       free;

    logic [15:0] enc_arr  [MOTOR_COUNT];
    logic [7:0]  want_arr [MOTOR_COUNT];
    logic [7:0]  dir_arr  [MOTOR_COUNT];
    logic [7:0]  act_arr  [MOTOR_COUNT];
    logic [7:0]  power_l  [MOTOR_COUNT];
    logic [7:0]  dir_l    [MOTOR_COUNT];
    logic [7:0]  act_l    [MOTOR_COUNT];

    assign enc_arr[0]  = sample.enc_a;
    assign enc_arr[1]  = sample.enc_b;
    assign enc_arr[2]  = sample.enc_c;
    assign want_arr[0] = sample.want_a;
    assign want_arr[1] = sample.want_b;
    assign want_arr[2] = sample.want_c;
    assign dir_arr[0]  = sample.dir_in_a;
    assign dir_arr[1]  = sample.dir_in_b;
    assign dir_arr[2]  = sample.dir_in_c;
    assign act_arr[0]  = sample.act_in_a;
    assign act_arr[1]  = sample.act_in_b;
    assign act_arr[2]  = sample.act_in_c;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain     <= PROP_GAIN_RST;
            cfg_reg.integ_gain    <= INTEG_GAIN_RST;
            cfg_reg.sample_period <= SAMPLE_PERIOD_RST;
            cfg_reg.power_limit   <= POWER_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_PROP_GAIN:     cfg_reg.prop_gain     <= cfg.data;
                CFG_INTEG_GAIN:    cfg_reg.integ_gain    <= cfg.data;
                CFG_SAMPLE_PERIOD: cfg_reg.sample_period <= cfg.data;
                CFG_POWER_LIMIT:   cfg_reg.power_limit   <= cfg.data[7:0];
            endcase
        end
    end

    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid && sample.ready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    step_next  = STEP_ERR_MUL;
                end
            end
            ST_RUN:
            begin
                if (step_reg == STEP_SLOPE)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_t'(step_reg + 3'd1);
                end
            end
            ST_DONE:
            begin
                // hold the lanes until the output register can take the item
                if (free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_ERR_MUL;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign ctrl.start = accept;
    assign ctrl.run   = (state_reg == ST_RUN);
    assign ctrl.step  = step_reg;

    for (genvar m = 0; m < MOTOR_COUNT; m++)
    begin : g_lane
        tmpsc_lane #(
            .LINE_IDX (m)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .cfg     (cfg_reg),
            .enc     (enc_arr[m]),
            .want    (want_arr[m]),
            .dir_in  (dir_arr[m]),
            .act_in  (act_arr[m]),
            .power   (power_l[m]),
            .dir_out (dir_l[m]),
            .act_out (act_l[m])
        );
    end

    tmpsc_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .power   (power_l),
        .dir_val (dir_l),
        .act_val (act_l),
        .free    (free),
        .result  (result)
    );

endmodule
